// ----- rtl/core/eqb_pkg.sv -----
// Shared types, widths, coefficients and microcode fields of the stereo three-band equalizer.
package eqb_pkg;

  localparam int CHANNELS   = 2;
  localparam int CH_W       = 1;
  localparam int SAMP_W     = 16;
  localparam int GAIN_W     = 10;
  localparam int Y_W        = 24;
  localparam int Y_FRAC     = 6;
  localparam int COEF_FRAC_BITS = 22;
  localparam int COEF_W     = COEF_FRAC_BITS + 2;
  localparam int COEF_SHIFT = 30 - COEF_FRAC_BITS;
  localparam int OUT_SHIFT  = Y_FRAC + 16;
  localparam int MID_W      = Y_W + 2;
  localparam int A_W        = 40;
  localparam int B_W        = COEF_W;
  localparam int P_W        = A_W + B_W;
  localparam int ACC_W      = 64;
  localparam int STEP_W     = 5;
  localparam int N_STEPS    = 18;

  // Coefficients are given with 30 fraction bits and rounded half up to the working format.
  function automatic longint coef_round(input longint c30);
    longint half;
    half = 64'sd0;
    if (COEF_SHIFT == 0) begin
      return c30;
    end
    half = 64'sd1 <<< (COEF_SHIFT - 1);
    return (c30 + half) >>> COEF_SHIFT;
  endfunction

  // Order: a0, a1, a2, b1, b2.
  localparam logic signed [COEF_W-1:0] LP_COEF [5] = '{
    COEF_W'(coef_round(64'sd4042638)),
    COEF_W'(coef_round(64'sd8084202)),
    COEF_W'(coef_round(64'sd4042638)),
    COEF_W'(coef_round(-64'sd1953234088)),
    COEF_W'(coef_round(64'sd895660669))
  };
  localparam logic signed [COEF_W-1:0] HP_COEF [5] = '{
    COEF_W'(coef_round(64'sd715797102)),
    COEF_W'(coef_round(-64'sd1431594204)),
    COEF_W'(coef_round(64'sd715797102)),
    COEF_W'(coef_round(-64'sd1308758139)),
    COEF_W'(coef_round(64'sd480689519))
  };

  typedef enum logic [1:0] {
    REG_LOW_GAIN    = 2'd0,
    REG_MID_GAIN    = 2'd1,
    REG_HIGH_GAIN   = 2'd2,
    REG_MASTER_GAIN = 2'd3
  } reg_idx_t;

  typedef enum logic [3:0] {
    A_X, A_X1, A_X2, A_LP1, A_LP2, A_HP1, A_HP2, A_LO, A_MID, A_HI, A_ACC
  } a_sel_t;

  typedef enum logic [3:0] {
    B_LP0, B_LP1, B_LP2, B_LP3, B_LP4,
    B_HP0, B_HP1, B_HP2, B_HP3, B_HP4,
    B_LG, B_MG, B_HG, B_MASTER
  } b_sel_t;

  typedef enum logic [1:0] {ACC_HOLD, ACC_LOAD, ACC_ADD, ACC_SUB} acc_op_t;

  typedef enum logic [1:0] {LAT_NONE, LAT_LO, LAT_HI, LAT_OUT} latch_t;

  typedef struct packed {
    a_sel_t  a_sel;
    b_sel_t  b_sel;
    acc_op_t acc_op;
    latch_t  latch;
    logic    last;
  } ctrl_t;

  localparam ctrl_t CTRL_NOP = '{A_X, B_LP0, ACC_HOLD, LAT_NONE, 1'b0};

  typedef struct packed {
    logic [GAIN_W-1:0] low;
    logic [GAIN_W-1:0] mid;
    logic [GAIN_W-1:0] high;
    logic [GAIN_W-1:0] master;
  } gains_t;

  typedef struct packed {
    logic signed [SAMP_W-1:0] left;
    logic signed [SAMP_W-1:0] right;
    logic                     clip;
  } eqb_result_t;

endpackage

// ----- rtl/core/eqb_ucode_rom.sv -----
// Microprogram table: one control word per step of a channel's computation.
module eqb_ucode_rom
  import eqb_pkg::*;
(
  input  logic [STEP_W-1:0] step,
  output ctrl_t             ctrl
);

  // The accumulate field acts on the product issued by the previous step.
  always_comb begin
    unique case (step)
      5'd0:  ctrl = '{A_X,   B_LP0,    ACC_HOLD, LAT_NONE, 1'b0};
      5'd1:  ctrl = '{A_X1,  B_LP1,    ACC_LOAD, LAT_NONE, 1'b0};
      5'd2:  ctrl = '{A_X2,  B_LP2,    ACC_ADD,  LAT_NONE, 1'b0};
      5'd3:  ctrl = '{A_LP1, B_LP3,    ACC_ADD,  LAT_NONE, 1'b0};
      5'd4:  ctrl = '{A_LP2, B_LP4,    ACC_SUB,  LAT_NONE, 1'b0};
      5'd5:  ctrl = '{A_X,   B_HP0,    ACC_SUB,  LAT_NONE, 1'b0};
      5'd6:  ctrl = '{A_X1,  B_HP1,    ACC_LOAD, LAT_LO,   1'b0};
      5'd7:  ctrl = '{A_X2,  B_HP2,    ACC_ADD,  LAT_NONE, 1'b0};
      5'd8:  ctrl = '{A_HP1, B_HP3,    ACC_ADD,  LAT_NONE, 1'b0};
      5'd9:  ctrl = '{A_HP2, B_HP4,    ACC_SUB,  LAT_NONE, 1'b0};
      5'd10: ctrl = '{A_LO,  B_LG,     ACC_SUB,  LAT_NONE, 1'b0};
      5'd11: ctrl = '{A_X,   B_LP0,    ACC_LOAD, LAT_HI,   1'b0};
      5'd12: ctrl = '{A_MID, B_MG,     ACC_HOLD, LAT_NONE, 1'b0};
      5'd13: ctrl = '{A_HI,  B_HG,     ACC_ADD,  LAT_NONE, 1'b0};
      5'd14: ctrl = '{A_X,   B_LP0,    ACC_ADD,  LAT_NONE, 1'b0};
      5'd15: ctrl = '{A_ACC, B_MASTER, ACC_HOLD, LAT_NONE, 1'b0};
      5'd16: ctrl = '{A_X,   B_LP0,    ACC_LOAD, LAT_NONE, 1'b0};
      5'd17: ctrl = '{A_X,   B_LP0,    ACC_HOLD, LAT_OUT,  1'b1};
      default: ctrl = CTRL_NOP;
    endcase
  end

endmodule

// ----- rtl/core/eqb_datapath.sv -----
// Shared multiplier, accumulator, filter history and result registers of the equalizer.
module eqb_datapath
  import eqb_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              load,
  input  logic [2*SAMP_W-1:0] samples,
  input  logic [CH_W-1:0]   ch,
  input  ctrl_t             ctrl,
  input  gains_t            gains,
  output eqb_result_t       result
);

  localparam logic signed [ACC_W-1:0] F_HALF = ACC_W'(1) <<< (COEF_FRAC_BITS - 1);
  localparam logic signed [ACC_W-1:0] O_HALF = ACC_W'(1) <<< (OUT_SHIFT - 1);
  localparam logic signed [ACC_W-1:0] Y_MAX  = ACC_W'((64'sd1 <<< (Y_W - 1)) - 64'sd1);
  localparam logic signed [ACC_W-1:0] Y_MIN  = -(ACC_W'(1) <<< (Y_W - 1));
  localparam logic signed [ACC_W-1:0] S_MAX  = ACC_W'((64'sd1 <<< (SAMP_W - 1)) - 64'sd1);
  localparam logic signed [ACC_W-1:0] S_MIN  = -(ACC_W'(1) <<< (SAMP_W - 1));

  logic signed [SAMP_W-1:0] samp_r [CHANNELS];
  logic signed [SAMP_W-1:0] x1_r   [CHANNELS];
  logic signed [SAMP_W-1:0] x2_r   [CHANNELS];
  logic signed [Y_W-1:0]    lp1_r  [CHANNELS];
  logic signed [Y_W-1:0]    lp2_r  [CHANNELS];
  logic signed [Y_W-1:0]    hp1_r  [CHANNELS];
  logic signed [Y_W-1:0]    hp2_r  [CHANNELS];
  logic signed [Y_W-1:0]    lo_r, hi_r;
  logic signed [P_W-1:0]    prod_r;
  logic signed [ACC_W-1:0]  acc_r;
  logic signed [SAMP_W-1:0] res_r  [CHANNELS];
  logic                     clip_r;

  logic signed [SAMP_W-1:0] x_cur;
  logic signed [MID_W-1:0]  x64, mid;
  logic signed [A_W-1:0]    op_a;
  logic signed [B_W-1:0]    op_b;
  logic signed [ACC_W-1:0]  prod_ext;
  logic signed [ACC_W-1:0]  f_shr, o_shr;
  logic signed [Y_W-1:0]    y_filt;
  logic signed [SAMP_W-1:0] y_out;
  logic                     o_clip;

  assign x_cur = samp_r[ch];
  assign x64   = MID_W'(x_cur) <<< Y_FRAC;
  assign mid   = x64 - MID_W'(lo_r) - MID_W'(hi_r);

  always_comb begin
    unique case (ctrl.a_sel)
      A_X:     op_a = A_W'(x64);
      A_X1:    op_a = A_W'(x1_r[ch]) <<< Y_FRAC;
      A_X2:    op_a = A_W'(x2_r[ch]) <<< Y_FRAC;
      A_LP1:   op_a = A_W'(lp1_r[ch]);
      A_LP2:   op_a = A_W'(lp2_r[ch]);
      A_HP1:   op_a = A_W'(hp1_r[ch]);
      A_HP2:   op_a = A_W'(hp2_r[ch]);
      A_LO:    op_a = A_W'(lo_r);
      A_MID:   op_a = A_W'(mid);
      A_HI:    op_a = A_W'(hi_r);
      A_ACC:   op_a = A_W'(acc_r);
      default: op_a = '0;
    endcase
  end

  always_comb begin
    unique case (ctrl.b_sel)
      B_LP0:    op_b = LP_COEF[0];
      B_LP1:    op_b = LP_COEF[1];
      B_LP2:    op_b = LP_COEF[2];
      B_LP3:    op_b = LP_COEF[3];
      B_LP4:    op_b = LP_COEF[4];
      B_HP0:    op_b = HP_COEF[0];
      B_HP1:    op_b = HP_COEF[1];
      B_HP2:    op_b = HP_COEF[2];
      B_HP3:    op_b = HP_COEF[3];
      B_HP4:    op_b = HP_COEF[4];
      B_LG:     op_b = $signed({{(B_W-GAIN_W){1'b0}}, gains.low});
      B_MG:     op_b = $signed({{(B_W-GAIN_W){1'b0}}, gains.mid});
      B_HG:     op_b = $signed({{(B_W-GAIN_W){1'b0}}, gains.high});
      B_MASTER: op_b = $signed({{(B_W-GAIN_W){1'b0}}, gains.master});
      default:  op_b = '0;
    endcase
  end

  assign prod_ext = ACC_W'(prod_r);

  // Filter output: round half up to Q.6 and saturate to 24 bits.
  assign f_shr = (acc_r + F_HALF) >>> COEF_FRAC_BITS;
  always_comb begin
    priority if (f_shr > Y_MAX) begin
      y_filt = Y_MAX[Y_W-1:0];
    end else if (f_shr < Y_MIN) begin
      y_filt = Y_MIN[Y_W-1:0];
    end else begin
      y_filt = f_shr[Y_W-1:0];
    end
  end

  // Final sample: round half up to an integer and saturate to 16 bits.
  assign o_shr = (acc_r + O_HALF) >>> OUT_SHIFT;
  always_comb begin
    priority if (o_shr > S_MAX) begin
      y_out  = S_MAX[SAMP_W-1:0];
      o_clip = 1'b1;
    end else if (o_shr < S_MIN) begin
      y_out  = S_MIN[SAMP_W-1:0];
      o_clip = 1'b1;
    end else begin
      y_out  = o_shr[SAMP_W-1:0];
      o_clip = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    prod_r <= op_a * op_b;
    unique case (ctrl.acc_op)
      ACC_HOLD: acc_r <= acc_r;
      ACC_LOAD: acc_r <= prod_ext;
      ACC_ADD:  acc_r <= acc_r + prod_ext;
      ACC_SUB:  acc_r <= acc_r - prod_ext;
      default:  acc_r <= acc_r;
    endcase
    if (load) begin
      samp_r[0] <= samples[SAMP_W-1:0];
      samp_r[1] <= samples[2*SAMP_W-1:SAMP_W];
    end
    if (ctrl.latch == LAT_LO) begin
      lo_r <= y_filt;
    end
    if (ctrl.latch == LAT_HI) begin
      hi_r <= y_filt;
    end
    if (ctrl.latch == LAT_OUT) begin
      res_r[ch] <= y_out;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clip_r <= 1'b0;
      for (int i = 0; i < CHANNELS; i++) begin
        x1_r[i]  <= '0;
        x2_r[i]  <= '0;
        lp1_r[i] <= '0;
        lp2_r[i] <= '0;
        hp1_r[i] <= '0;
        hp2_r[i] <= '0;
      end
    end else begin
      if (load) begin
        clip_r <= 1'b0;
      end else if (ctrl.latch == LAT_OUT) begin
        clip_r   <= clip_r | o_clip;
        x2_r[ch]  <= x1_r[ch];
        x1_r[ch]  <= x_cur;
        lp2_r[ch] <= lp1_r[ch];
        lp1_r[ch] <= lo_r;
        hp2_r[ch] <= hp1_r[ch];
        hp1_r[ch] <= hi_r;
      end
    end
  end

  assign result = '{res_r[0], res_r[1], clip_r};

endmodule

// ----- rtl/core/stereo_three_band_equalizer.sv -----
// Top level of the stereo three-band equalizer: sequencer, gain registers and stream ports.
// A frame is taken only while the sequencer is idle; a microprogram of 18 steps per channel runs
// both channels through a single shared multiplier and accumulator.
// Reset (rst_n low, synchronous) clears filter history, the sequencer and the output valid,
// and sets all four gains to 128.
module stereo_three_band_equalizer
  import eqb_pkg::*;
(
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_tvalid,
  output logic                in_tready,
  input  logic [2*SAMP_W-1:0] in_tdata,   // [15:0] left_sample, [31:16] right_sample
  output logic                out_tvalid,
  input  logic                out_tready,
  output logic [2*SAMP_W-1:0] out_tdata,  // [15:0] left_out, [31:16] right_out
  output logic                out_tuser,  // [0] clipped
  input  logic                cfg_valid,
  output logic                cfg_ready,
  input  logic [1:0]          cfg_index,
  input  logic [GAIN_W-1:0]   cfg_data
);

  typedef enum logic [1:0] {ST_IDLE, ST_RUN, ST_DONE} state_t;

  state_t              state_r;
  logic [STEP_W-1:0]   step_r;
  logic [CH_W-1:0]     ch_r;
  gains_t              gains_r;
  logic                out_tvalid_r;
  logic [2*SAMP_W-1:0] out_tdata_r;
  logic                out_tuser_r;

  ctrl_t       rom_word, ctrl;
  eqb_result_t result;
  logic        in_accept, out_free;

  assign in_tready = (state_r == ST_IDLE);
  assign in_accept = in_tvalid && in_tready;
  assign out_free  = !out_tvalid_r || out_tready;
  assign cfg_ready = 1'b1;

  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = out_tdata_r;
  assign out_tuser  = out_tuser_r;

  eqb_ucode_rom u_rom (
    .step (step_r),
    .ctrl (rom_word)
  );

  assign ctrl = (state_r == ST_RUN) ? rom_word : CTRL_NOP;

  eqb_datapath u_dp (
    .clk     (clk),
    .rst_n   (rst_n),
    .load    (in_accept),
    .samples (in_tdata),
    .ch      (ch_r),
    .ctrl    (ctrl),
    .gains   (gains_r),
    .result  (result)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      gains_r <= '{10'd128, 10'd128, 10'd128, 10'd128};
    end else if (cfg_valid && cfg_ready) begin
      unique case (reg_idx_t'(cfg_index))
        REG_LOW_GAIN:    gains_r.low    <= cfg_data;
        REG_MID_GAIN:    gains_r.mid    <= cfg_data;
        REG_HIGH_GAIN:   gains_r.high   <= cfg_data;
        REG_MASTER_GAIN: gains_r.master <= cfg_data;
        default:         gains_r        <= gains_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_IDLE;
      step_r       <= '0;
      ch_r         <= '0;
      out_tvalid_r <= 1'b0;
    end else begin
      // A finishing frame reloads the output register in the cycle its beat leaves.
      if (out_tvalid_r && out_tready && state_r != ST_DONE) begin
        out_tvalid_r <= 1'b0;
      end
      unique case (state_r)
        ST_IDLE: begin
          if (in_accept) begin
            state_r <= ST_RUN;
            step_r  <= '0;
            ch_r    <= '0;
          end
        end
        ST_RUN: begin
          // End of a channel's program: loop back for the right channel, else finish.
          if (rom_word.last) begin
            step_r <= '0;
            if (ch_r == CH_W'(CHANNELS - 1)) begin
              state_r <= ST_DONE;
            end else begin
              ch_r <= ch_r + 1'b1;
            end
          end else begin
            step_r <= step_r + 1'b1;
          end
        end
        ST_DONE: begin
          if (out_free) begin
            out_tvalid_r <= 1'b1;
            out_tdata_r  <= {result.right, result.left};
            out_tuser_r  <= result.clip;
            state_r      <= ST_IDLE;
          end
        end
        default: state_r <= ST_IDLE;
      endcase
    end
  end

  a_start: assert property (@(posedge clk) disable iff (!rst_n)
    in_accept |=> (state_r == ST_RUN) && (step_r == '0) && (ch_r == '0))
    else $error("sequencer did not start at the first step of the left channel");

  a_step_range: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_RUN) |-> (step_r < STEP_W'(N_STEPS)))
    else $error("step counter ran past the microprogram");

  a_finish: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_RUN && rom_word.last && ch_r == CH_W'(CHANNELS - 1)) |=>
      (state_r == ST_DONE))
    else $error("sequencer did not finish after the right channel");

  a_out_src: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_tvalid_r) |-> ($past(state_r) == ST_DONE))
    else $error("result beat raised outside the finishing state");

endmodule

// ----- tb/equalizer_checker.sv -----
// Checker for the stereo equalizer: predicts each frame from the observed beats and compares.
`timescale 1ns / 1ps
module equalizer_checker
  import eqb_pkg::*;
(
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_tvalid,
  input  logic                in_tready,
  input  logic [2*SAMP_W-1:0] in_tdata,
  input  logic                out_tvalid,
  input  logic                out_tready,
  input  logic [2*SAMP_W-1:0] out_tdata,
  input  logic                out_tuser,
  input  logic                cfg_valid,
  input  logic                cfg_ready,
  input  logic [1:0]          cfg_index,
  input  logic [GAIN_W-1:0]   cfg_data,
  output int                  frames_pending,
  output int                  mismatch_count
);

  // Filter coefficients with 30 fraction bits, in the order a0, a1, a2, b1, b2.
  localparam longint LOWPASS_C30 [5] = '{
    64'sd4042638, 64'sd8084202, 64'sd4042638, -64'sd1953234088, 64'sd895660669
  };
  localparam longint HIGHPASS_C30 [5] = '{
    64'sd715797102, -64'sd1431594204, 64'sd715797102, -64'sd1308758139, 64'sd480689519
  };
  localparam longint Q6_MAX = 64'sd8388607;
  localparam longint Q6_MIN = -64'sd8388608;

  logic [GAIN_W-1:0] low_gain, mid_gain, high_gain, master_gain;

  // Per-channel history: previous inputs and previous band outputs (Q.6).
  logic signed [SAMP_W-1:0] x_d1 [CHANNELS];
  logic signed [SAMP_W-1:0] x_d2 [CHANNELS];
  logic signed [Y_W-1:0]    lp_d1 [CHANNELS];
  logic signed [Y_W-1:0]    lp_d2 [CHANNELS];
  logic signed [Y_W-1:0]    hp_d1 [CHANNELS];
  logic signed [Y_W-1:0]    hp_d2 [CHANNELS];

  eqb_result_t expected_frames [$];
  eqb_result_t want;

  // Half-up rounding is a floor shift after adding half an LSB.
  function automatic longint round_half_up(input longint v, input int s);
    if (s <= 0) return v;
    return (v + (longint'(1) <<< (s - 1))) >>> s;
  endfunction

  function automatic longint coef_q(input bit highpass, input int k);
    return round_half_up(highpass ? HIGHPASS_C30[k] : LOWPASS_C30[k], 30 - COEF_FRAC_BITS);
  endfunction

  function automatic logic signed [Y_W-1:0] biquad_q6(
    input bit highpass,
    input logic signed [SAMP_W-1:0] x, x1, x2,
    input logic signed [Y_W-1:0] y1, y2
  );
    longint acc;
    acc = coef_q(highpass, 0) * (longint'(x) * 64)
        + coef_q(highpass, 1) * (longint'(x1) * 64)
        + coef_q(highpass, 2) * (longint'(x2) * 64)
        - coef_q(highpass, 3) * longint'(y1)
        - coef_q(highpass, 4) * longint'(y2);
    acc = round_half_up(acc, COEF_FRAC_BITS);
    if (acc > Q6_MAX) acc = Q6_MAX;
    if (acc < Q6_MIN) acc = Q6_MIN;
    return acc[Y_W-1:0];
  endfunction

  // Runs one stereo frame through both channels and advances the filter history.
  function automatic eqb_result_t equalize_frame(input logic [2*SAMP_W-1:0] frame);
    eqb_result_t res;
    logic signed [SAMP_W-1:0] x;
    logic signed [Y_W-1:0] lo, hi;
    logic signed [SAMP_W-1:0] y_out [CHANNELS];
    longint mid, sum, y;
    res.clip = 1'b0;
    for (int ch = 0; ch < CHANNELS; ch++) begin
      x   = frame[ch*SAMP_W +: SAMP_W];
      lo  = biquad_q6(1'b0, x, x_d1[ch], x_d2[ch], lp_d1[ch], lp_d2[ch]);
      hi  = biquad_q6(1'b1, x, x_d1[ch], x_d2[ch], hp_d1[ch], hp_d2[ch]);
      mid = longint'(x) * 64 - longint'(lo) - longint'(hi);
      sum = longint'(lo) * longint'(low_gain) + mid * longint'(mid_gain)
          + longint'(hi) * longint'(high_gain);
      y   = round_half_up(sum * longint'(master_gain), OUT_SHIFT);
      if (y > 64'sd32767) begin
        y = 64'sd32767;
        res.clip = 1'b1;
      end
      if (y < -64'sd32768) begin
        y = -64'sd32768;
        res.clip = 1'b1;
      end
      y_out[ch] = y[SAMP_W-1:0];
      x_d2[ch]  = x_d1[ch];
      x_d1[ch]  = x;
      lp_d2[ch] = lp_d1[ch];
      lp_d1[ch] = lo;
      hp_d2[ch] = hp_d1[ch];
      hp_d1[ch] = hi;
    end
    res.left  = y_out[0];
    res.right = y_out[1];
    return res;
  endfunction

  task automatic report_mismatch(input string msg);
    mismatch_count++;
    $display("%0t mismatch: %s", $realtime, msg);
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      low_gain    = 10'd128;
      mid_gain    = 10'd128;
      high_gain   = 10'd128;
      master_gain = 10'd128;
      for (int ch = 0; ch < CHANNELS; ch++) begin
        x_d1[ch]  = '0;
        x_d2[ch]  = '0;
        lp_d1[ch] = '0;
        lp_d2[ch] = '0;
        hp_d1[ch] = '0;
        hp_d2[ch] = '0;
      end
      expected_frames.delete();
      mismatch_count = 0;
      frames_pending <= 0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          REG_LOW_GAIN:    low_gain    = cfg_data;
          REG_MID_GAIN:    mid_gain    = cfg_data;
          REG_HIGH_GAIN:   high_gain   = cfg_data;
          REG_MASTER_GAIN: master_gain = cfg_data;
          default: ;
        endcase
      end
      if (out_tvalid && out_tready) begin
        if (expected_frames.size() == 0) begin
          report_mismatch($sformatf("output beat %h/%b with no frame pending",
                                    out_tdata, out_tuser));
        end else begin
          want = expected_frames.pop_front();
          if (out_tdata[15:0] !== want.left)
            report_mismatch($sformatf("left_out %0d, expected %0d",
                                      $signed(out_tdata[15:0]), want.left));
          if (out_tdata[31:16] !== want.right)
            report_mismatch($sformatf("right_out %0d, expected %0d",
                                      $signed(out_tdata[31:16]), want.right));
          if (out_tuser !== want.clip)
            report_mismatch($sformatf("clipped %b, expected %b", out_tuser, want.clip));
        end
      end
      if (in_tvalid && in_tready) expected_frames.push_back(equalize_frame(in_tdata));
      frames_pending <= expected_frames.size();
    end
  end

endmodule

// ----- tb/stereo_three_band_equalizer_tb.sv -----
// Testbench top for the stereo equalizer: clock, reset, frame and gain stimulus, verdict.
`timescale 1ns / 1ps
module stereo_three_band_equalizer_tb;
  import eqb_pkg::*;

  localparam int CYCLE_LIMIT   = 1000000;
  localparam int HOLD_CYCLES   = 600;
  localparam int FRAMES_CHUNK  = 121;
  localparam int TAIL_CYCLES   = 60;

  logic                clk = 1'b0;
  logic                rst_n = 1'b0;
  logic                in_tvalid = 1'b0;
  logic                in_tready;
  logic [2*SAMP_W-1:0] in_tdata = '0;
  logic                out_tvalid;
  logic                out_tready = 1'b0;
  logic [2*SAMP_W-1:0] out_tdata;
  logic                out_tuser;
  logic                cfg_valid = 1'b0;
  logic                cfg_ready;
  logic [1:0]          cfg_index = '0;
  logic [GAIN_W-1:0]   cfg_data = '0;

  int frames_pending;
  int mismatch_count;
  int cycle_count = 0;
  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  int hold_left = 0;
  logic start_hold = 1'b0;
  logic signed [SAMP_W-1:0] prev_left = '0;
  logic signed [SAMP_W-1:0] prev_right = '0;

  always #5 clk = ~clk;

  stereo_three_band_equalizer DUT (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  equalizer_checker checker_i (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_tvalid      (in_tvalid),
    .in_tready      (in_tready),
    .in_tdata       (in_tdata),
    .out_tvalid     (out_tvalid),
    .out_tready     (out_tready),
    .out_tdata      (out_tdata),
    .out_tuser      (out_tuser),
    .cfg_valid      (cfg_valid),
    .cfg_ready      (cfg_ready),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data),
    .frames_pending (frames_pending),
    .mismatch_count (mismatch_count)
  );

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  // Output side: random back-pressure, plus a long hold-off on request.
  always @(posedge clk) begin
    if (!rst_n) begin
      out_tready <= 1'b0;
      hold_left  <= 0;
    end else if (start_hold) begin
      out_tready <= 1'b0;
      hold_left  <= HOLD_CYCLES;
    end else if (hold_left != 0) begin
      out_tready <= 1'b0;
      hold_left  <= hold_left - 1;
    end else begin
      out_tready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  // Valid is only lowered while idling, so back-to-back beats keep it high.
  task automatic send_frame(input logic signed [SAMP_W-1:0] left, right);
    while ($urandom_range(99) < send_idle_pct) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= {right, left};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
  endtask

  task automatic drain_frames();
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (frames_pending != 0) @(posedge clk);
  endtask

  task automatic write_reg(input reg_idx_t idx, input logic [GAIN_W-1:0] value);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
  endtask

  task automatic set_gains(input logic [GAIN_W-1:0] lg, mg, hg, mst);
    write_reg(REG_LOW_GAIN, lg);
    write_reg(REG_MID_GAIN, mg);
    write_reg(REG_HIGH_GAIN, hg);
    write_reg(REG_MASTER_GAIN, mst);
    cfg_valid <= 1'b0;
  endtask

  // Mostly in range, with the edges and the full 10-bit code now and then.
  function automatic logic [GAIN_W-1:0] pick_gain();
    case ($urandom_range(7))
      0: return 10'd0;
      1: return 10'd512;
      2: return 10'd256;
      3: return 10'd1023;
      default: return GAIN_W'($urandom_range(512));
    endcase
  endfunction

  function automatic logic signed [SAMP_W-1:0] pick_sample(input logic signed [SAMP_W-1:0] prev);
    case ($urandom_range(9))
      0: return 16'sh7FFF;
      1: return 16'sh8000;
      2: return prev;
      3, 4: return SAMP_W'($urandom_range(511)) - 16'sd256;
      default: return SAMP_W'($urandom);
    endcase
  endfunction

  initial begin
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Reset gains: silence, full-scale steps, DC at both rails and the Nyquist tone.
    send_frame(16'sd0, 16'sd0);
    send_frame(16'sh7FFF, 16'sh8000);
    send_frame(16'sh8000, 16'sh7FFF);
    repeat (3) send_frame(16'sh7FFF, 16'sh7FFF);
    repeat (3) send_frame(16'sh8000, 16'sh8000);
    repeat (2) begin
      send_frame(16'sh7FFF, 16'sh8000);
      send_frame(16'sh8000, 16'sh7FFF);
    end
    send_frame(16'sd1, -16'sd1);
    send_frame(-16'sd1, 16'sd1);

    // All gains at the full code, so the outputs clip on both rails.
    drain_frames();
    set_gains(10'd1023, 10'd1023, 10'd1023, 10'd1023);
    repeat (2) begin
      send_frame(16'sh7FFF, 16'sh8000);
      send_frame(16'sh8000, 16'sh7FFF);
    end
    send_frame(16'sd256, -16'sd256);

    drain_frames();
    set_gains(10'd0, 10'd0, 10'd0, 10'd0);
    send_frame(16'sh7FFF, 16'sh8000);
    send_frame(16'sh8000, 16'sh7FFF);

    for (int phase = 0; phase < 3; phase++) begin
      for (int chunk = 0; chunk < 4; chunk++) begin
        drain_frames();
        if (chunk == 0) begin
          send_idle_pct = (phase == 0) ? 23 : (phase == 1) ? 87 : 0;
          recv_idle_pct <= (phase == 0) ? 87 : (phase == 1) ? 23 : 0;
        end
        set_gains(pick_gain(), pick_gain(), pick_gain(), pick_gain());
        if (phase == 2 && chunk == 0) begin
          // Stall the output long enough for the input to back up.
          start_hold <= 1'b1;
          @(posedge clk);
          start_hold <= 1'b0;
        end
        repeat (FRAMES_CHUNK) begin
          prev_left  = pick_sample(prev_left);
          prev_right = pick_sample(prev_right);
          send_frame(prev_left, prev_right);
        end
      end
    end

    drain_frames();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
